// File: rtl/core/pclp_pkg.sv
package pclp_pkg;

  localparam int NUM_PROCESSES = 32;
  localparam int NUM_CALLS     = 27;
  localparam int TABLE_SIZE    = NUM_PROCESSES * NUM_CALLS;
  localparam int ADDR_W        = $clog2(TABLE_SIZE);
  localparam int DATA_W        = 32;
  localparam int STAT_W        = 2 * DATA_W;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int STEP_W        = $clog2(DATA_W);
  localparam int PROC_W        = 5;
  localparam int CALL_W        = 5;
  localparam int FUNC_W        = 2;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_WB,
    ST_RESULT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SWEEP,
    OP_BEGIN,
    OP_LOOKUP,
    OP_END_LOAD,
    OP_MUL,
    OP_ADD,
    OP_DIV,
    OP_WB
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    func_e in_func;
    logic  addr_ok;
    logic  end_ok;
    logic  sweep_last;
    logic  div_last;
    logic  out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/pclp_ram.sv
module pclp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pclp_ctrl.sv
module pclp_ctrl
  import pclp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.op = OP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = (sts_i.in_func == FUNC_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_CLEAR: begin
        cmd_o.op = OP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_READ: begin
        state_d = sts_i.addr_ok ? ST_EXEC : ST_RESULT;
      end
      ST_EXEC: begin
        state_d = ST_RESULT;
        unique case (sts_i.in_func)
          FUNC_BEGIN: cmd_o.op = OP_BEGIN;
          FUNC_END: begin
            if (sts_i.end_ok) begin
              cmd_o.op = OP_END_LOAD;
              state_d  = ST_MUL;
            end else begin
              cmd_o.op = OP_LOOKUP;
            end
          end
          FUNC_READ:  cmd_o.op = OP_LOOKUP;
          FUNC_CLEAR: cmd_o.op = OP_NONE;
          default:    cmd_o.op = OP_NONE;
        endcase
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.op = OP_ADD;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        cmd_o.op = OP_WB;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

endmodule

// File: rtl/core/pclp_dp.sv
module pclp_dp
  import pclp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic [FUNC_W-1:0]      in_user_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_user_o,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o
);

  func_e              func_q;
  logic [PROC_W-1:0]  proc_q;
  logic [CALL_W-1:0]  call_q;
  logic [DATA_W-1:0]  ts_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               addr_ok_q;
  logic [PROC_W-1:0]  in_proc;
  logic [CALL_W-1:0]  in_call;
  logic               in_ok;

  logic [NUM_PROCESSES-1:0] track_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic [STEP_W-1:0]  step_q;

  logic [DATA_W-1:0]  cnt_q, mean_q, elapsed_q, rem_q, quo_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  total;
  logic [DATA_W:0]    trial;
  logic               qbit;

  logic [DATA_W-1:0]  res_count_q, res_mean_q;
  logic               res_upd_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_count_q, out_mean_q;
  logic               out_upd_q;

  logic               stat_we, begin_we;
  logic [ADDR_W-1:0]  stat_addr;
  logic [STAT_W-1:0]  stat_wdata, stat_rdata;
  logic [DATA_W-1:0]  begin_rdata;
  logic [DATA_W-1:0]  cnt_rd, mean_rd, cnt_inc;

  assign in_proc = in_data_i[PROC_W-1:0];
  assign in_call = in_data_i[PROC_W+CALL_W-1:PROC_W];
  assign in_ok   = (int'(in_proc) < NUM_PROCESSES) && (int'(in_call) < NUM_CALLS);

  assign cnt_rd  = stat_rdata[DATA_W-1:0];
  assign mean_rd = stat_rdata[STAT_W-1:DATA_W];
  assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + DATA_W'(1);

  assign total = prod_q + PROD_W'(elapsed_q);
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign qbit  = (trial >= {1'b0, cnt_q});

  always_comb begin
    stat_we    = 1'b0;
    begin_we   = 1'b0;
    stat_addr  = addr_q;
    stat_wdata = {mean_rd, cnt_inc};
    unique case (cmd_i.op)
      OP_SWEEP: begin
        stat_we    = 1'b1;
        stat_addr  = sweep_q;
        stat_wdata = '0;
      end
      OP_BEGIN: begin
        stat_we  = 1'b1;
        begin_we = 1'b1;
      end
      OP_WB: begin
        stat_we    = 1'b1;
        stat_wdata = {quo_q, cnt_q};
      end
      default: stat_we = 1'b0;
    endcase
  end

  pclp_ram #(.WIDTH(STAT_W), .DEPTH(TABLE_SIZE)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .addr_i  (stat_addr),
    .wdata_i (stat_wdata),
    .rdata_o (stat_rdata)
  );

  pclp_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_begin_ram (
    .clk_i   (clk_i),
    .we_i    (begin_we),
    .addr_i  (addr_q),
    .wdata_i (ts_q),
    .rdata_o (begin_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q     <= '0;
      sweep_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SWEEP) begin
        sweep_q <= (sweep_q == ADDR_W'(TABLE_SIZE - 1)) ? '0 : sweep_q + ADDR_W'(1);
      end
      if (cmd_i.op == OP_BEGIN) begin
        track_q[proc_q] <= 1'b1;
      end
      if (cmd_i.op == OP_ADD) begin
        step_q <= '0;
      end else if (cmd_i.op == OP_DIV) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        func_q      <= func_e'(in_user_i);
        proc_q      <= in_proc;
        call_q      <= in_call;
        ts_q        <= in_data_i[PROC_W+CALL_W+DATA_W-1:PROC_W+CALL_W];
        addr_ok_q   <= in_ok;
        addr_q      <= ADDR_W'(in_proc) * ADDR_W'(NUM_CALLS) + ADDR_W'(in_call);
        res_count_q <= '0;
        res_mean_q  <= '0;
        res_upd_q   <= 1'b0;
      end
      OP_BEGIN: begin
        res_count_q <= cnt_inc;
        res_mean_q  <= mean_rd;
      end
      OP_LOOKUP: begin
        res_count_q <= cnt_rd;
        res_mean_q  <= mean_rd;
      end
      OP_END_LOAD: begin
        cnt_q     <= cnt_rd;
        mean_q    <= mean_rd;
        elapsed_q <= ts_q - begin_rdata;
      end
      OP_MUL: begin
        prod_q <= PROD_W'(mean_q) * PROD_W'(cnt_q - DATA_W'(1));
      end
      OP_ADD: begin
        rem_q <= total[PROD_W-1:DATA_W];
        quo_q <= total[DATA_W-1:0];
      end
      OP_DIV: begin
        rem_q <= qbit ? DATA_W'(trial - {1'b0, cnt_q}) : trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], qbit};
      end
      OP_WB: begin
        res_count_q <= cnt_q;
        res_mean_q  <= quo_q;
        res_upd_q   <= 1'b1;
      end
      default: begin
        res_upd_q <= res_upd_q;
      end
    endcase
    if (cmd_i.out_load) begin
      out_count_q <= res_count_q;
      out_mean_q  <= res_mean_q;
      out_upd_q   <= res_upd_q;
    end
  end

  assign sts_o.in_func    = (cmd_i.op == OP_CAPTURE) ? func_e'(in_user_i) : func_q;
  assign sts_o.addr_ok    = addr_ok_q;
  assign sts_o.end_ok     = track_q[proc_q] && (cnt_rd != '0);
  assign sts_o.sweep_last = (sweep_q == ADDR_W'(TABLE_SIZE - 1));
  assign sts_o.div_last   = (step_q == STEP_W'(DATA_W - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_mean_q, out_count_q};
  assign out_user_o  = out_upd_q;

  logic unused_call;
  assign unused_call = ^call_q;

endmodule

// File: rtl/core/per_process_call_latency_profiler.sv
// Latency profiler over a table of 32 processes by 27 call numbers. Each input beat
// is one event (clear, call begin, call end, read) and yields exactly one output beat
// with the addressed entry's count and average after the event; average_updated marks
// an end event that folded its elapsed time into the average. An applicable end event
// runs a 32x32 multiply, a 64-bit add and then the restoring divider, which produces
// one quotient bit per cycle. Begin and read events skip these steps. A clear event,
// and the first pass after reset, sweep the statistics memory one entry per cycle
// while s_axis_tready stays low. The next event is accepted while a result still waits
// in the output register.
module per_process_call_latency_profiler
  import pclp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // process_index, call_index, timestamp
  input  logic [FUNC_W-1:0]      s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // call_count, average_time
  output logic                   m_axis_tuser   // average_updated
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pclp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pclp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: rtl/core/pclp_checker.sv
module pclp_checker
  import pclp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [FUNC_W-1:0]      s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_no_accept_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !s_axis_tready)
    else $error("ready high during reset");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat accepted while busy");

  a_update_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[DATA_W-1:0] != '0)
    else $error("average updated on empty entry");

  a_zero_count_zero_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[DATA_W-1:0] == '0) |->
      m_axis_tdata[OUT_TDATA_W-1:DATA_W] == '0)
    else $error("nonzero average on entry without calls");

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

endmodule

bind per_process_call_latency_profiler pclp_checker u_pclp_checker (.*);

// File: sim/per_process_call_latency_profiler_test.sv
module per_process_call_latency_profiler_test;
  import pclp_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_EVENTS = 650;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int DRAIN_CYCLES  = 100;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic [DATA_W-1:0] call_count;
    logic [DATA_W-1:0] average_time;
    logic              average_updated;
  } entry_stats_t;

  typedef struct packed {
    func_e              func;
    logic [PROC_W-1:0]  proc;
    logic [CALL_W-1:0]  call;
    logic [DATA_W-1:0]  stamp;
    logic               known;
    entry_stats_t       want;
  } event_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  per_process_call_latency_profiler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic              proc_tracked [NUM_PROCESSES];
  logic [DATA_W-1:0] call_start   [TABLE_SIZE];
  logic [DATA_W-1:0] call_total   [TABLE_SIZE];
  logic [DATA_W-1:0] call_mean    [TABLE_SIZE];

  entry_stats_t pending_stats [$];
  bit           failed        = 1'b0;
  int           cycle_count   = 0;
  int           src_idle_pct  = 33;
  int           sink_idle_pct = 33;
  bit           hold_off_req  = 1'b0;
  int           hold_off_left = 0;
  int           events_sent   = 0;

  event_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_READ,  5'd0,  5'd0,  32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_END,   5'd7,  5'd3,  32'd123,        1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd3,  5'd5,  32'd100,        1'b1, '{32'd1, 32'd0,          1'b0}},
    '{FUNC_END,   5'd3,  5'd5,  32'd350,        1'b1, '{32'd1, 32'd250,        1'b1}},
    '{FUNC_BEGIN, 5'd3,  5'd5,  32'hFFFFFF00,   1'b1, '{32'd2, 32'd250,        1'b0}},
    '{FUNC_END,   5'd3,  5'd5,  32'h00000064,   1'b0, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_READ,  5'd3,  5'd27, 32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd3,  5'd31, 32'hFFFFFFFF,   1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_END,   5'd3,  5'd31, 32'd5,          1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_READ,  5'd3,  5'd5,  32'hFFFFFFFF,   1'b0, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd31, 5'd26, 32'hFFFFFFFF,   1'b1, '{32'd1, 32'd0,          1'b0}},
    '{FUNC_END,   5'd31, 5'd26, 32'hFFFFFFFE,   1'b1, '{32'd1, 32'hFFFFFFFF,   1'b1}},
    '{FUNC_BEGIN, 5'd31, 5'd26, 32'd0,          1'b1, '{32'd2, 32'hFFFFFFFF,   1'b0}},
    '{FUNC_END,   5'd31, 5'd26, 32'hFFFFFFFF,   1'b1, '{32'd2, 32'hFFFFFFFF,   1'b1}},
    '{FUNC_END,   5'd31, 5'd26, 32'hFFFFFFFF,   1'b1, '{32'd2, 32'hFFFFFFFF,   1'b1}},
    '{FUNC_CLEAR, 5'd31, 5'd26, 32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_READ,  5'd3,  5'd5,  32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_END,   5'd3,  5'd5,  32'd500,        1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd0,  5'd0,  32'd0,          1'b1, '{32'd1, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd0,  5'd0,  32'd10,         1'b1, '{32'd2, 32'd0,          1'b0}},
    '{FUNC_END,   5'd0,  5'd0,  32'd17,         1'b0, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_CLEAR, 5'd31, 5'd31, 32'hFFFFFFFF,   1'b1, '{32'd0, 32'd0,          1'b0}},
    '{FUNC_BEGIN, 5'd3,  5'd5,  32'd1000,       1'b1, '{32'd1, 32'd0,          1'b0}},
    '{FUNC_END,   5'd3,  5'd5,  32'd999,        1'b1, '{32'd1, 32'hFFFFFFFF,   1'b1}},
    '{FUNC_READ,  5'd31, 5'd26, 32'd0,          1'b1, '{32'd0, 32'd0,          1'b0}}
  };

  function automatic entry_stats_t apply_profile_event(func_e f, logic [PROC_W-1:0] p,
                                                       logic [CALL_W-1:0] c,
                                                       logic [DATA_W-1:0] stamp);
    entry_stats_t      r;
    bit                hit;
    int                idx;
    int                i;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] prev_n;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] quot;
    r   = '0;
    hit = (int'(p) < NUM_PROCESSES) && (int'(c) < NUM_CALLS);
    idx = hit ? int'(p) * NUM_CALLS + int'(c) : 0;
    case (f)
      FUNC_CLEAR: begin
        for (i = 0; i < TABLE_SIZE; i++) begin
          call_total[i] = '0;
          call_mean[i]  = '0;
        end
      end
      FUNC_BEGIN: begin
        if (hit) begin
          proc_tracked[p] = 1'b1;
          call_start[idx] = stamp;
          if (call_total[idx] != '1) call_total[idx] = call_total[idx] + 1;
        end
      end
      FUNC_END: begin
        if (hit && proc_tracked[p] && call_total[idx] != '0) begin
          elapsed        = stamp - call_start[idx];
          prev_n         = call_total[idx] - 1;
          sum            = PROD_W'(call_mean[idx]) * PROD_W'(prev_n) + PROD_W'(elapsed);
          quot           = sum / PROD_W'(call_total[idx]);
          call_mean[idx] = quot[DATA_W-1:0];
          r.average_updated = 1'b1;
        end
      end
      default: ;
    endcase
    if (hit) begin
      r.call_count   = call_total[idx];
      r.average_time = call_mean[idx];
    end
    return r;
  endfunction

  task automatic send_beat(func_e f, logic [PROC_W-1:0] p, logic [CALL_W-1:0] c,
                           logic [DATA_W-1:0] stamp);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {{(IN_TDATA_W - DATA_W - CALL_W - PROC_W){1'b0}}, stamp, c, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic issue_event(func_e f, logic [PROC_W-1:0] p, logic [CALL_W-1:0] c,
                             logic [DATA_W-1:0] stamp);
    send_beat(f, p, c, stamp);
    pending_stats.push_back(apply_profile_event(f, p, c, stamp));
    events_sent++;
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [PROC_W-1:0] pick_proc();
    return ($urandom_range(0, 3) == 0) ? PROC_W'($urandom_range(0, 31))
                                       : PROC_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [CALL_W-1:0] pick_call();
    return ($urandom_range(0, 3) == 0) ? CALL_W'($urandom_range(0, 31))
                                       : CALL_W'($urandom_range(NUM_CALLS - 3, NUM_CALLS - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_span();
    return ($urandom_range(0, 3) == 0) ? DATA_W'($urandom) : DATA_W'($urandom_range(0, 5000));
  endfunction

  task automatic check_beat();
    entry_stats_t want;
    if (pending_stats.size() == 0) begin
      $error("unexpected output beat: call_count %0d average_time %0d average_updated %0d",
             m_axis_tdata[DATA_W-1:0], m_axis_tdata[2*DATA_W-1:DATA_W], m_axis_tuser);
      failed = 1'b1;
    end else begin
      want = pending_stats.pop_front();
      if (m_axis_tdata[DATA_W-1:0] !== want.call_count) begin
        $error("call_count: expected %0d, got %0d", want.call_count,
               m_axis_tdata[DATA_W-1:0]);
        failed = 1'b1;
      end
      if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.average_time) begin
        $error("average_time: expected %0d, got %0d", want.average_time,
               m_axis_tdata[2*DATA_W-1:DATA_W]);
        failed = 1'b1;
      end
      if (m_axis_tuser !== want.average_updated) begin
        $error("average_updated: expected %0d, got %0d", want.average_updated, m_axis_tuser);
        failed = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_beat();
    if (hold_off_req) begin
      hold_off_left = HOLD_OFF_LEN;
      hold_off_req  = 1'b0;
    end
    if (hold_off_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("per_process_call_latency_profiler regression: fail");
      $finish;
    end
  end

  initial begin
    int                i;
    int                roll;
    bit                hold_off_done;
    bit                pause_done;
    entry_stats_t      got;
    logic [PROC_W-1:0] p;
    logic [CALL_W-1:0] c;
    logic [DATA_W-1:0] tick;
    hold_off_done = 1'b0;
    pause_done    = 1'b0;
    tick          = $urandom;
    for (i = 0; i < NUM_PROCESSES; i++) proc_tracked[i] = 1'b0;
    for (i = 0; i < TABLE_SIZE; i++) begin
      call_start[i] = '0;
      call_total[i] = '0;
      call_mean[i]  = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_beat(directed_rows[i].func, directed_rows[i].proc, directed_rows[i].call,
                directed_rows[i].stamp);
      got = apply_profile_event(directed_rows[i].func, directed_rows[i].proc,
                                directed_rows[i].call, directed_rows[i].stamp);
      pending_stats.push_back(directed_rows[i].known ? directed_rows[i].want : got);
    end

    idle_input();
    drain_results();

    events_sent = 0;
    while (events_sent < RANDOM_EVENTS) begin
      if (!hold_off_done && events_sent >= 150) begin
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
      end
      if (events_sent >= 350 && events_sent < 450) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 33;
        sink_idle_pct = 33;
      end
      if (!pause_done && events_sent >= 500) begin
        idle_input();
        drain_results();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) tick = $urandom;
      roll = $urandom_range(0, 99);
      p    = pick_proc();
      c    = pick_call();
      if (roll < 60) begin
        issue_event(FUNC_BEGIN, p, c, tick);
        if ($urandom_range(0, 3) == 0) issue_event(FUNC_READ, pick_proc(), pick_call(), $urandom);
        tick = tick + pick_span();
        issue_event(FUNC_END, p, c, tick);
        if ($urandom_range(0, 4) == 0) issue_event(FUNC_READ, p, c, $urandom);
      end else if (roll < 75) begin
        issue_event(FUNC_READ, p, c, $urandom);
      end else if (roll < 89) begin
        issue_event(FUNC_END, PROC_W'($urandom_range(0, 31)), CALL_W'($urandom_range(0, 31)),
                    $urandom);
      end else if (roll < 98) begin
        issue_event(FUNC_BEGIN, PROC_W'($urandom_range(0, 31)), CALL_W'($urandom_range(0, 31)),
                    $urandom);
      end else begin
        issue_event(FUNC_CLEAR, PROC_W'($urandom_range(0, 31)), CALL_W'($urandom_range(0, 31)),
                    $urandom);
      end
      tick = tick + DATA_W'($urandom_range(0, 300));
    end

    idle_input();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("per_process_call_latency_profiler regression: pass");
    end else begin
      $display("per_process_call_latency_profiler regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pclp_pkg.sv
rtl/core/pclp_ram.sv
rtl/core/pclp_ctrl.sv
rtl/core/pclp_dp.sv
rtl/core/per_process_call_latency_profiler.sv
rtl/core/pclp_checker.sv
sim/per_process_call_latency_profiler_test.sv
